// ----- design/sdtq_pkg.sv -----
package sdtq_pkg;

    // fixed field widths
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_KEY_W  = 16;
    localparam int OUT_KEY_W = 16;

    // most results one tick may produce
    localparam int MAX_OUT = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                add;
        logic                remove;
        logic                pop;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } sdtq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              found;
        logic              head_reached;
        logic              next_reached;
        logic              out_free;
    } sdtq_stat_t;

endpackage

// ----- design/sdtq_datapath.sv -----
module sdtq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sdtq_pkg::sdtq_cmd_t                  cmd,
    output sdtq_pkg::sdtq_stat_t                 stat,
    input  logic [sdtq_pkg::KIND_W-1:0]          kind,
    input  logic [sdtq_pkg::DELAY_W-1:0]         delay_ticks,
    input  logic [sdtq_pkg::IN_KEY_W-1:0]        key,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sdtq_pkg::STATUS_W-1:0]        status,
    output logic [sdtq_pkg::OUT_KEY_W-1:0]       expired_key,
    output logic                                 last
);
    import sdtq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // time advanced by tick items, and fill count
    logic [TIME_W-1:0]    time_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    // captured item
    logic [KIND_W-1:0]    kind_reg;
    logic [TIME_W-1:0]    new_dl_reg;
    logic [KEY_WIDTH-1:0] new_key_reg;

    // cell chain
    logic [TIME_W-1:0]    cell_dl_reg  [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] cell_key_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0]    prev_dl      [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] prev_key     [QUEUE_DEPTH];
    logic [TIME_W-1:0]    up_dl        [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0] up_key       [QUEUE_DEPTH];
    logic [TIME_W-1:0]    diff         [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] vld;
    logic [QUEUE_DEPTH-1:0] later;
    logic [QUEUE_DEPTH-1:0] sel_src;
    logic [QUEUE_DEPTH-1:0] sel;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] rsel;
    logic [QUEUE_DEPTH-1:0] take_new;
    logic [QUEUE_DEPTH-1:0] take_prev;

    // output beat register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [OUT_KEY_W-1:0] expired_key_reg;
    logic                 last_reg;

    logic [KEY_WIDTH+IN_KEY_W-1:0]  key_in_ext;
    logic [KEY_WIDTH+OUT_KEY_W-1:0] head_key_ext;
    logic [TIME_W-1:0]              tdiff0;
    logic [TIME_W-1:0]              tdiff1;

    // key masked to the stored width
    assign key_in_ext   = {{KEY_WIDTH{1'b0}}, key};
    assign head_key_ext = {{OUT_KEY_W{1'b0}}, cell_key_reg[0]};

    // per-cell compares against the captured item
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            vld[i]     = CW'(i) < count_reg;
            diff[i]    = new_dl_reg - cell_dl_reg[i];
            later[i]   = vld[i] & diff[i][TIME_W-1];
            sel_src[i] = vld[i] ? later[i] : 1'b1;
            match[i]   = vld[i] && (cell_key_reg[i] == new_key_reg);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel[i]  = |(sel_src & ~({QUEUE_DEPTH{1'b1}} << (i + 1)));
            rsel[i] = |(match & ~({QUEUE_DEPTH{1'b1}} << (i + 1)));
        end
    end

    // neighbor taps of the chain
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_tap
        if (gi == 0)
        begin : g_first
            assign prev_dl[gi]   = cell_dl_reg[gi];
            assign prev_key[gi]  = cell_key_reg[gi];
            assign take_new[gi]  = sel[gi];
            assign take_prev[gi] = 1'b0;
        end
        else
        begin : g_rest
            assign prev_dl[gi]   = cell_dl_reg[gi-1];
            assign prev_key[gi]  = cell_key_reg[gi-1];
            assign take_new[gi]  = sel[gi] & ~sel[gi-1];
            assign take_prev[gi] = sel[gi] & sel[gi-1];
        end
        if (gi == QUEUE_DEPTH - 1)
        begin : g_end
            assign up_dl[gi]  = cell_dl_reg[gi];
            assign up_key[gi] = cell_key_reg[gi];
        end
        else
        begin : g_mid
            assign up_dl[gi]  = cell_dl_reg[gi+1];
            assign up_key[gi] = cell_key_reg[gi+1];
        end
    end

    // cell chain update
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cmd.add)
            begin
                if (take_new[i])
                begin
                    cell_dl_reg[i]  <= new_dl_reg;
                    cell_key_reg[i] <= new_key_reg;
                end
                else if (take_prev[i])
                begin
                    cell_dl_reg[i]  <= prev_dl[i];
                    cell_key_reg[i] <= prev_key[i];
                end
            end
            else if (cmd.pop || (cmd.remove && rsel[i]))
            begin
                cell_dl_reg[i]  <= up_dl[i];
                cell_key_reg[i] <= up_key[i];
            end
        end
    end

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.remove || cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && kind == KIND_TICK)
            begin
                time_reg <= time_reg + TIME_W'(1);
            end
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            new_dl_reg  <= time_reg + delay_ticks;
            new_key_reg <= key_in_ext[KEY_WIDTH-1:0];
        end
        if (cmd.emit)
        begin
            status_reg      <= cmd.emit_status;
            expired_key_reg <= (cmd.emit_status == ST_EXPIRED) ?
                               head_key_ext[OUT_KEY_W-1:0] : '0;
            last_reg        <= cmd.emit_last;
        end
    end

    // head expiry checks, wrap safe
    assign tdiff0 = time_reg - cell_dl_reg[0];
    assign tdiff1 = time_reg - cell_dl_reg[1];

    assign stat.kind         = kind_reg;
    assign stat.full         = count_reg == CW'(QUEUE_DEPTH);
    assign stat.found        = |match;
    assign stat.head_reached = (count_reg != '0) && !tdiff0[TIME_W-1];
    assign stat.next_reached = (count_reg > CW'(1)) && !tdiff1[TIME_W-1];
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign expired_key = expired_key_reg;
    assign last        = last_reg;

endmodule

// ----- design/sdtq_ctrl.sv -----
module sdtq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output sdtq_pkg::sdtq_cmd_t  cmd,
    input  sdtq_pkg::sdtq_stat_t stat
);
    import sdtq_pkg::*;

    localparam int PW = $clog2(MAX_OUT);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [PW-1:0] pops_reg;
    logic [PW-1:0] pops_next;
    logic          pop_last;

    assign pop_last = (pops_reg == PW'(MAX_OUT - 1)) || !stat.next_reached;

    // command decode
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        pops_next   = pops_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pops_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    unique case (stat.kind)
                        KIND_TICK:
                        begin
                            if (stat.head_reached)
                            begin
                                cmd.pop         = 1'b1;
                                cmd.emit_status = ST_EXPIRED;
                                cmd.emit_last   = pop_last;
                                if (!pop_last)
                                begin
                                    pops_next  = pops_reg + PW'(1);
                                    state_next = S_EXEC;
                                end
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                            end
                        end
                        KIND_ADD:
                        begin
                            cmd.add         = !stat.full;
                            cmd.emit_status = stat.full ? ST_FULL : ST_OK;
                        end
                        KIND_REMOVE:
                        begin
                            cmd.remove      = stat.found;
                            cmd.emit_status = stat.found ? ST_OK : ST_NOTFOUND;
                        end
                        default:
                        begin
                            cmd.emit_status = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and pop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pops_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pops_reg  <= pops_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result beat issued while output register occupied");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.add, cmd.remove, cmd.pop}))
        else $error("more than one queue operation in a cycle");

    a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> stat.head_reached)
        else $error("pop of an entry that has not expired");

    a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> stat.found)
        else $error("remove without a matching entry");

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC) && (pops_reg == '0))
        else $error("accepted item did not start execution");
`endif

endmodule

// ----- design/sorted_deadline_timer_queue_core.sv -----
// Sorted deadline timer queue. Holds up to QUEUE_DEPTH timers in a chain of
// cells kept in deadline order (ties in arrival order); deadlines are 32-bit
// tick counts compared wrap safe. A tick item advances time by one and pops
// every expired front entry, one expired-key beat each (at most 16 per tick,
// last flag on the final one), or gives one ok beat if nothing expired. An
// add inserts current time plus delay (status full if the queue is full); a
// remove drops the first matching key (status not found if none). Each item
// is captured, then executed: the chain shifts and the result beat is loaded
// into the output register once it is free or draining. A tick pops one
// expired entry per cycle from the head while the output is not stalled.
// The next item is accepted only after the last beat of the current one has
// been loaded into the output register.
module sorted_deadline_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sdtq_pkg::KIND_W-1:0]     kind,
    input  logic [sdtq_pkg::DELAY_W-1:0]    delay_ticks,
    input  logic [sdtq_pkg::IN_KEY_W-1:0]   key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sdtq_pkg::STATUS_W-1:0]   status,
    output logic [sdtq_pkg::OUT_KEY_W-1:0]  expired_key,
    output logic                            last
);
    import sdtq_pkg::*;

    sdtq_cmd_t  cmd;
    sdtq_stat_t stat;

    // sequencing
    sdtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // cell chain, time and output register
    sdtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .delay_ticks (delay_ticks),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .expired_key (expired_key),
        .last        (last)
    );

endmodule
